/* src/tcw_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the tagged control word sequencer.
// Depends on nothing; every other source file imports it.

package tcw_pkg;

    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned CFG_DATA_W = 32;

    // Register indexes on the configuration port (byte address 4 * index).
    localparam logic [1:0] REG_FIRST_SLAVE  = 2'd0;
    localparam logic [1:0] REG_SECOND_SLAVE = 2'd1;
    localparam logic [1:0] REG_TARGET       = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [3:0] FIRST_SLAVE_RST  = 4'd6;
    localparam logic [3:0] SECOND_SLAVE_RST = 4'd7;
    localparam logic [4:0] TARGET_RST       = 5'd1;

    // RFFE register-write command code.
    localparam logic [2:0] RFFE_CMD_WRITE = 3'b010;

    typedef enum logic [1:0] {
        KIND_CTRL   = 2'd0,
        KIND_FRAME1 = 2'd1,
        KIND_FRAME2 = 2'd2
    } tcw_kind_t;

    typedef struct packed {
        logic [3:0] first_slave_id;
        logic [3:0] second_slave_id;
        logic [4:0] target_register;
    } tcw_cfg_t;

    // Everything one completed sequence produces.
    typedef struct packed {
        logic [7:0]  dac_code;
        logic        main_ldo_on;
        logic        aux_ldo_on;
        logic [7:0]  switch_pattern;
        logic [23:0] frame1_word;
        logic [23:0] frame2_word;
    } tcw_result_set_t;

    // Odd parity bit over the command header and over the data byte.
    function automatic logic [23:0] build_frame(input logic [3:0] usid,
                                                input logic [4:0] addr,
                                                input logic [6:0] data);
        logic [11:0] head;
        head = {usid, RFFE_CMD_WRITE, addr};
        return {head, ~(^head), 1'b0, data, ~(^data), 2'b00};
    endfunction

    // A switch field whose low bit is set contributes nothing.
    function automatic logic [7:0] switch_map(input logic [5:0] fields);
        logic [7:0] pat;
        pat = 8'h00;
        if (!fields[3])
        begin
            pat[7:6] = fields[5:4];
        end
        if (!fields[0])
        begin
            pat[5:4] = fields[2:1];
        end
        return pat;
    endfunction

endpackage

/* src/tcw_cfg_regs.sv */
`timescale 1ns / 1ps
// Configuration register file behind the APB-style port.
// Depends on tcw_pkg for register indexes, reset values and the config struct.

module tcw_cfg_regs
    import tcw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output tcw_cfg_t              cfg
);

    tcw_cfg_t   cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_slave_id  <= FIRST_SLAVE_RST;
            cfg_reg.second_slave_id <= SECOND_SLAVE_RST;
            cfg_reg.target_register <= TARGET_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_FIRST_SLAVE:  cfg_reg.first_slave_id  <= pwdata[3:0];
                REG_SECOND_SLAVE: cfg_reg.second_slave_id <= pwdata[3:0];
                REG_TARGET:       cfg_reg.target_register <= pwdata[4:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            REG_FIRST_SLAVE:  prdata[3:0] = cfg_reg.first_slave_id;
            REG_SECOND_SLAVE: prdata[3:0] = cfg_reg.second_slave_id;
            REG_TARGET:       prdata[4:0] = cfg_reg.target_register;
            default:          prdata = '0;
        endcase
    end

endmodule

/* src/tcw_receiver.sv */
`timescale 1ns / 1ps
// Five-phase tag receiver that collects the control bytes and builds the result set.
// Depends on tcw_pkg for the config and result structs and the frame helpers.

module tcw_receiver
    import tcw_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      port_value,
    input  tcw_cfg_t        cfg,
    output logic            at_final,
    output logic            done,
    output tcw_result_set_t result_set
);

    typedef enum logic [2:0] {
        PH_SWITCH = 3'd0,
        PH_DAC_LO = 3'd1,
        PH_DAC_HI = 3'd2,
        PH_DATA1  = 3'd3,
        PH_DATA2  = 3'd4
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [5:0] switch_fields_reg, switch_fields_next;
    logic [5:0] dac_low_reg, dac_low_next;
    logic [3:0] dac_high_ldo_reg, dac_high_ldo_next;
    logic [6:0] data1_reg, data1_next;
    logic [1:0] tag;

    assign tag      = port_value[7:6];
    assign at_final = (phase_reg == PH_DATA2);

    always_comb
    begin
        phase_next         = phase_reg;
        switch_fields_next = switch_fields_reg;
        dac_low_next       = dac_low_reg;
        dac_high_ldo_next  = dac_high_ldo_reg;
        data1_next         = data1_reg;
        done               = 1'b0;
        if (accept)
        begin
            case (phase_reg)
                PH_SWITCH:
                begin
                    if (tag == 2'b11)
                    begin
                        switch_fields_next = port_value[5:0];
                        phase_next         = PH_DAC_LO;
                    end
                end
                PH_DAC_LO:
                begin
                    if (tag == 2'b10)
                    begin
                        dac_low_next = port_value[5:0];
                        phase_next   = PH_DAC_HI;
                    end
                end
                PH_DAC_HI:
                begin
                    if (tag == 2'b01)
                    begin
                        dac_high_ldo_next = port_value[3:0];
                        phase_next        = PH_DATA1;
                    end
                end
                PH_DATA1:
                begin
                    if (port_value[7])
                    begin
                        data1_next = port_value[6:0];
                        phase_next = PH_DATA2;
                    end
                end
                PH_DATA2:
                begin
                    if (!port_value[7])
                    begin
                        done       = 1'b1;
                        phase_next = PH_SWITCH;
                    end
                end
                default:
                begin
                    phase_next = PH_SWITCH;
                end
            endcase
        end
    end

    // The result set is only taken by the queue on the completing word.
    always_comb
    begin
        result_set.dac_code       = {dac_high_ldo_reg[3:2], dac_low_reg};
        result_set.main_ldo_on    = dac_high_ldo_reg[1];
        result_set.aux_ldo_on     = dac_high_ldo_reg[0];
        result_set.switch_pattern = switch_map(switch_fields_reg);
        result_set.frame1_word    = build_frame(cfg.first_slave_id, cfg.target_register,
                                                data1_reg);
        result_set.frame2_word    = build_frame(cfg.second_slave_id, cfg.target_register,
                                                port_value[6:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_SWITCH;
            switch_fields_reg <= '0;
            dac_low_reg       <= '0;
            dac_high_ldo_reg  <= '0;
            data1_reg         <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            switch_fields_reg <= switch_fields_next;
            dac_low_reg       <= dac_low_next;
            dac_high_ldo_reg  <= dac_high_ldo_next;
            data1_reg         <= data1_next;
        end
    end

endmodule

/* src/tcw_result_queue.sv */
`timescale 1ns / 1ps
// Result register that holds one completed set and hands out its three words in order.
// Depends on tcw_pkg for the result set struct and the kind codes.

module tcw_result_queue
    import tcw_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  tcw_result_set_t result_set,
    input  logic            out_stall,
    output logic            busy,
    output logic            out_valid,
    output logic [1:0]      kind,
    output logic [7:0]      dac_code,
    output logic            main_ldo_on,
    output logic            aux_ldo_on,
    output logic [7:0]      switch_pattern,
    output logic [23:0]     frame_word,
    output logic            last
);

    tcw_result_set_t set_reg;
    tcw_kind_t       idx_reg, idx_next;
    logic            busy_reg, busy_next;
    logic            take;

    assign busy      = busy_reg;
    assign out_valid = busy_reg;
    assign take      = busy_reg && !out_stall;

    always_comb
    begin
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (load)
        begin
            idx_next  = KIND_CTRL;
            busy_next = 1'b1;
        end
        else if (take)
        begin
            case (idx_reg)
                KIND_CTRL:   idx_next = KIND_FRAME1;
                KIND_FRAME1: idx_next = KIND_FRAME2;
                KIND_FRAME2:
                begin
                    idx_next  = KIND_CTRL;
                    busy_next = 1'b0;
                end
                default:
                begin
                    idx_next  = KIND_CTRL;
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= KIND_CTRL;
            busy_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            set_reg <= result_set;
        end
    end

    always_comb
    begin
        kind           = idx_reg;
        dac_code       = '0;
        main_ldo_on    = 1'b0;
        aux_ldo_on     = 1'b0;
        switch_pattern = '0;
        frame_word     = '0;
        last           = 1'b0;
        case (idx_reg)
            KIND_CTRL:
            begin
                dac_code       = set_reg.dac_code;
                main_ldo_on    = set_reg.main_ldo_on;
                aux_ldo_on     = set_reg.aux_ldo_on;
                switch_pattern = set_reg.switch_pattern;
            end
            KIND_FRAME1: frame_word = set_reg.frame1_word;
            KIND_FRAME2:
            begin
                frame_word = set_reg.frame2_word;
                last       = 1'b1;
            end
            default: kind = KIND_CTRL;
        endcase
    end

    // A new set must never overwrite one that is still being delivered.
    a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !busy_reg)
        else $error("result set loaded while previous set still pending");

    // Taking the last word of a set frees the register.
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (take && idx_reg == KIND_FRAME2 && !load) |=> !busy_reg)
        else $error("queue still busy after last word was taken");

    // A stalled word keeps its position in the set.
    a_stall_holds_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && out_stall && !load) |=> ($stable(idx_reg) && busy_reg))
        else $error("word index moved while output stalled");

    // The first word after a load is always the control update.
    a_load_starts_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (busy_reg && idx_reg == KIND_CTRL))
        else $error("set did not start with the control update");

endmodule

/* src/tagged_control_word_rffe_sequencer_top.sv */
`timescale 1ns / 1ps
// Top level of the tagged control word sequencer.
// Depends on tcw_pkg, tcw_cfg_regs, tcw_receiver and tcw_result_queue.
//
// Usage:
// The input channel (in_valid, in_stall, port_value) carries one sample of the
// parallel port per word. A word is taken at each rising edge where in_valid is
// high and in_stall is low; one word can be taken every cycle.
// The receiver walks five phases (switch byte, DAC low, DAC high and LDO enables,
// first RFFE data, second RFFE data) and ignores any word whose tag does not fit.
// The word that completes the second data phase produces three output words:
// the control update, then the first and the second RFFE register-write frames.
// The output channel (out_valid, out_stall and the result fields) presents them
// starting the cycle after that word is taken, one per cycle while not stalled.
// Results are held in a single result register set. A sequence needs at least
// five input words, so a set is normally drained long before the next one
// completes; in_stall is raised only while a set is still pending and the
// receiver waits for its final word, which keeps the input flowing otherwise.
// When the downstream side stalls the output (out_stall high), the presented word holds unchanged.
// Reset (rst_n low, asynchronous) returns the receiver to the switch phase, empties
// the result register and loads the slave ids 6 and 7 and target register 1.
// Configuration registers sit at byte addresses 0, 4 and 8 of the APB port.

module tagged_control_word_rffe_sequencer_top
    import tcw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // APB-style configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    // Input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            port_value,
    // Output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            kind,
    output logic [7:0]            dac_code,
    output logic                  main_ldo_on,
    output logic                  aux_ldo_on,
    output logic [7:0]            switch_pattern,
    output logic [23:0]           frame_word,
    output logic                  last
);

    tcw_cfg_t        cfg;
    tcw_result_set_t result_set;
    logic            accept;
    logic            at_final;
    logic            done;
    logic            busy;

    // Stall only when the next word could complete a set while one is pending.
    assign in_stall = busy && at_final;
    assign accept   = in_valid && !in_stall;

    tcw_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tcw_receiver u_rx (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .port_value (port_value),
        .cfg        (cfg),
        .at_final   (at_final),
        .done       (done),
        .result_set (result_set)
    );

    tcw_result_queue u_queue (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (done),
        .result_set     (result_set),
        .out_stall      (out_stall),
        .busy           (busy),
        .out_valid      (out_valid),
        .kind           (kind),
        .dac_code       (dac_code),
        .main_ldo_on    (main_ldo_on),
        .aux_ldo_on     (aux_ldo_on),
        .switch_pattern (switch_pattern),
        .frame_word     (frame_word),
        .last           (last)
    );

endmodule
